[rtl/core/sts_pkg.sv]
// Shared types, constants and table function for the sine trajectory setpoint block.
package sts_pkg;

  // Fixed-point shifts
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int SIN_SHIFT       = 15;
  localparam int SAFE_SHIFT      = 15;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 22;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // 26214/32768 of the limit distance bounds the amplitude
  localparam logic signed [MUL_B_W-1:0] SAFE_SCALE = 18'sd26214;

  // Velocity saturation bounds (20-bit signed output)
  localparam logic signed [21:0] VEL_MAX = 22'sd524287;
  localparam logic signed [21:0] VEL_MIN = -22'sd524288;

  // pi/4, used when building the sine table
  localparam real QUARTER_PI = 0.78539816339744830962;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_OMEGA_RATE   = 3'd1,
    REG_CENTER_ANGLE = 3'd2,
    REG_PRESET_AMP   = 3'd3,
    REG_LOWER_LIMIT  = 3'd4,
    REG_UPPER_LIMIT  = 3'd5,
    REG_RUN_TICKS    = 3'd6,
    REG_PHASE_OFFSET = 3'd7
  } cfg_idx_e;

  // Configuration register file contents
  typedef struct packed {
    logic        [31:0] phase_step;
    logic        [16:0] omega_rate;
    logic signed [15:0] center_angle;
    logic        [14:0] preset_amplitude;
    logic signed [15:0] lower_limit;
    logic signed [15:0] upper_limit;
    logic        [23:0] run_ticks;
    logic        [31:0] phase_offset;
  } cfg_t;

  // Tick sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAFE,
    ST_AMP,
    ST_POS,
    ST_AW,
    ST_VEL,
    ST_OUT
  } seq_state_e;

  // Reciprocal of a positive value below 2048 by Newton iteration, elaboration only
  function automatic real recip(input real d);
    real r;
    int  n;
    r = 0.0009765625;
    for (n = 0; n < 24; n++) begin
      r = r * (2.0 - d * r);
    end
    return r;
  endfunction

  // Quarter-wave entry i: round(32767*sin((i+0.5)*pi/(2*2^bits))), evaluated at elaboration
  function automatic int sine_entry(input int bits, input int i);
    real x;
    real x2;
    real term;
    real sum;
    real sgn;
    int  k;
    x    = (2.0 * i + 1.0) * QUARTER_PI * (0.5 ** bits);
    x2   = x * x;
    term = x;
    sum  = x;
    sgn  = -1.0;
    for (k = 1; k <= 14; k++) begin
      term = term * x2 * recip((2.0 * k) * (2.0 * k + 1.0));
      sum  = sum + sgn * term;
      sgn  = -sgn;
    end
    if (sum > 1.0) sum = 1.0;
    return $rtoi(sum * 32767.0 + 0.5);
  endfunction

endpackage

[rtl/core/sts_if.sv]
// Valid/ready channel interfaces: tick input, setpoint output and configuration writes.

interface sts_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic stop_request;

  modport source (output valid, output restart, output stop_request, input ready);
  modport sink   (input valid, input restart, input stop_request, output ready);
endinterface

interface sts_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] position_cmd;
  logic signed [19:0] velocity_cmd;
  logic               clamped;
  logic               done_res;

  modport source (output valid, output position_cmd, output velocity_cmd, output clamped,
                  output done_res, input ready);
  modport sink   (input valid, input position_cmd, input velocity_cmd, input clamped,
                  input done_res, output ready);
endinterface

interface sts_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/sts_cfg_regs.sv]
// Configuration register file with reset values.
module sts_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  sts_cfg_if.sink       cfg_i,
  output sts_pkg::cfg_t cfg_o
);

  sts_pkg::cfg_t cfg_q;
  sts_pkg::cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (sts_pkg::cfg_idx_e'(cfg_i.index))
        sts_pkg::REG_PHASE_STEP:   cfg_d.phase_step       = cfg_i.data;
        sts_pkg::REG_OMEGA_RATE:   cfg_d.omega_rate       = cfg_i.data[16:0];
        sts_pkg::REG_CENTER_ANGLE: cfg_d.center_angle     = cfg_i.data[15:0];
        sts_pkg::REG_PRESET_AMP:   cfg_d.preset_amplitude = cfg_i.data[14:0];
        sts_pkg::REG_LOWER_LIMIT:  cfg_d.lower_limit      = cfg_i.data[15:0];
        sts_pkg::REG_UPPER_LIMIT:  cfg_d.upper_limit      = cfg_i.data[15:0];
        sts_pkg::REG_RUN_TICKS:    cfg_d.run_ticks        = cfg_i.data[23:0];
        sts_pkg::REG_PHASE_OFFSET: cfg_d.phase_offset     = cfg_i.data;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step       <= 32'd3865471;
      cfg_q.omega_rate       <= 17'd23162;
      cfg_q.center_angle     <= 16'sd0;
      cfg_q.preset_amplitude <= 15'd3277;
      cfg_q.lower_limit      <= -16'sd25736;
      cfg_q.upper_limit      <= 16'sd25736;
      cfg_q.run_ticks        <= 24'd300000;
      cfg_q.phase_offset     <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/core/sts_wave.sv]
// Quarter-wave sine table with quadrant folding; gives sine and cosine of a phase.
module sts_wave #(
  parameter int QUARTER_TABLE_BITS = 8
) (
  input  logic        [31:0] phase_i,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] cos_o
);

  localparam int TBL_SIZE = 1 << QUARTER_TABLE_BITS;

  logic [14:0] rom [TBL_SIZE];
  logic [1:0]  quad;
  logic [1:0]  quad_cos;
  logic [QUARTER_TABLE_BITS-1:0] idx;
  logic [14:0] sin_mag;
  logic [14:0] cos_mag;

  // Constant table, filled at elaboration
  for (genvar g = 0; g < TBL_SIZE; g++) begin : g_rom
    assign rom[g] = 15'(sts_pkg::sine_entry(QUARTER_TABLE_BITS, g));
  end

  assign quad     = phase_i[31:30];
  assign quad_cos = quad + 2'd1;
  assign idx      = phase_i[29 -: QUARTER_TABLE_BITS];

  // Odd quadrants read the table mirrored; upper half negates
  always_comb begin
    sin_mag = quad[0]     ? rom[~idx] : rom[idx];
    cos_mag = quad_cos[0] ? rom[~idx] : rom[idx];
    sin_o   = quad[1]     ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
    cos_o   = quad_cos[1] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
  end

endmodule

[rtl/core/sts_mul.sv]
// Shared signed multiplier with registered product.
module sts_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [sts_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [sts_pkg::MUL_B_W-1:0] b_i,
  output logic signed [sts_pkg::MUL_P_W-1:0] p_o
);

  logic signed [sts_pkg::MUL_P_W-1:0] p_q;
  logic signed [sts_pkg::MUL_P_W-1:0] p_d;

  assign p_d = sts_pkg::MUL_P_W'(a_i) * sts_pkg::MUL_P_W'(b_i);
  assign p_o = p_q;

  // Payload register, no reset; holds while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

endmodule

[rtl/core/sine_trajectory_setpoint.sv]
// Sine trajectory setpoint generator: one joint setpoint per control tick.
// Each accepted tick item yields one setpoint item: position = center + A*sin(phase),
// velocity = A*omega*cos(phase), clamped to the joint limits, with the phase accumulator
// advancing per moving tick. A moving tick steps through the states SAFE, AMP, POS, AW, VEL
// and OUT; its result is loaded into the output register from OUT, after which the block
// returns to IDLE and the next tick can be taken; a finished tick goes from IDLE straight
// to OUT. The sequence follows from the single shared multiplier, used four times in
// sequence (amplitude bound, position, amplitude*omega, velocity). The output register
// holds a result while the next tick is already being taken; a new result waits only while
// the previous one is still untaken, and the block stays busy for that long. Configuration
// writes are taken in any cycle and must only be issued while the block is idle.
module sine_trajectory_setpoint #(
  parameter int QUARTER_TABLE_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sts_cfg_if.sink    cfg_i,
  sts_in_if.sink     in_i,
  sts_out_if.source  out_o
);

  localparam int AW = sts_pkg::MUL_A_W;
  localparam int BW = sts_pkg::MUL_B_W;
  localparam int PW = sts_pkg::MUL_P_W;

  sts_pkg::cfg_t cfg;

  sts_pkg::seq_state_e state_q, state_d;

  // Tick state
  logic [23:0] cnt_q, cnt_d;
  logic [31:0] phase_q, phase_d;
  logic        fin_q, fin_d;

  // Working registers
  logic signed [16:0] amp_q, amp_d;
  logic signed [17:0] pos_q, pos_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] pos_out_q, pos_out_d;
  logic signed [19:0] vel_out_q, vel_out_d;
  logic               clamped_q, clamped_d;
  logic               done_q, done_d;

  // Datapath signals
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic                 mul_en;
  logic signed [15:0]   sin_val;
  logic signed [15:0]   cos_val;
  logic signed [16:0]   du;
  logic signed [16:0]   dl;
  logic signed [16:0]   dmin;
  logic signed [16:0]   safe;
  logic signed [16:0]   preset_s;
  logic signed [21:0]   vel_raw;
  logic signed [19:0]   vel_sat;
  logic signed [17:0]   lower_s;
  logic signed [17:0]   upper_s;
  logic [23:0]          cnt_eff;
  logic [31:0]          phase_eff;
  logic                 fin_eff;
  logic                 in_acc;
  logic                 out_free;

  sts_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sts_wave #(
    .QUARTER_TABLE_BITS (QUARTER_TABLE_BITS)
  ) u_wave (
    .phase_i (phase_q),
    .sin_o   (sin_val),
    .cos_o   (cos_val)
  );

  // Product holds in the output step so a stalled result keeps its velocity
  assign mul_en = (state_q != sts_pkg::ST_OUT);

  sts_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Handshakes
  assign in_i.ready = (state_q == sts_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid        = out_valid_q;
  assign out_o.position_cmd = pos_out_q;
  assign out_o.velocity_cmd = vel_out_q;
  assign out_o.clamped      = clamped_q;
  assign out_o.done_res     = done_q;

  // Restart, stop and run-time checks on the incoming tick
  always_comb begin
    cnt_eff   = in_i.restart ? 24'd0 : cnt_q;
    phase_eff = in_i.restart ? cfg.phase_offset : phase_q;
    fin_eff   = (in_i.restart ? 1'b0 : fin_q) | in_i.stop_request |
                (cnt_eff >= cfg.run_ticks);
  end

  // Amplitude bound, clamp operands and velocity saturation
  always_comb begin
    du       = {cfg.upper_limit[15], cfg.upper_limit} - {cfg.center_angle[15], cfg.center_angle};
    dl       = {cfg.center_angle[15], cfg.center_angle} - {cfg.lower_limit[15], cfg.lower_limit};
    dmin     = (du < dl) ? du : dl;
    safe     = prod[31:15];
    preset_s = {2'b00, cfg.preset_amplitude};
    lower_s  = {cfg.lower_limit[15], cfg.lower_limit[15], cfg.lower_limit};
    upper_s  = {cfg.upper_limit[15], cfg.upper_limit[15], cfg.upper_limit};
    vel_raw  = prod[36:15];
    if (vel_raw > sts_pkg::VEL_MAX) vel_sat = sts_pkg::VEL_MAX[19:0];
    else if (vel_raw < sts_pkg::VEL_MIN) vel_sat = sts_pkg::VEL_MIN[19:0];
    else vel_sat = vel_raw[19:0];
  end

  // Multiplier operand select
  always_comb begin
    case (state_q)
      sts_pkg::ST_SAFE: begin
        mul_a = AW'(dmin);
        mul_b = sts_pkg::SAFE_SCALE;
      end
      sts_pkg::ST_POS: begin
        mul_a = AW'(amp_q);
        mul_b = BW'(sin_val);
      end
      sts_pkg::ST_AW: begin
        mul_a = AW'(amp_q);
        mul_b = $signed({1'b0, cfg.omega_rate});
      end
      sts_pkg::ST_VEL: begin
        mul_a = prod[sts_pkg::ANGLE_FRAC_BITS +: AW];
        mul_b = BW'(cos_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer: next state, tick state and output register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    fin_d       = fin_q;
    amp_d       = amp_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    pos_out_d   = pos_out_q;
    vel_out_d   = vel_out_q;
    clamped_d   = clamped_q;
    done_d      = done_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      sts_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_d   = cnt_eff;
          phase_d = phase_eff;
          fin_d   = fin_eff;
          state_d = fin_eff ? sts_pkg::ST_OUT : sts_pkg::ST_SAFE;
        end
      end
      sts_pkg::ST_SAFE: state_d = sts_pkg::ST_AMP;
      sts_pkg::ST_AMP: begin
        amp_d   = (preset_s < safe) ? preset_s : safe;
        state_d = sts_pkg::ST_POS;
      end
      sts_pkg::ST_POS: state_d = sts_pkg::ST_AW;
      sts_pkg::ST_AW: begin
        pos_d   = {cfg.center_angle[15], cfg.center_angle[15], cfg.center_angle} +
                  {prod[31], prod[31:15]};
        state_d = sts_pkg::ST_VEL;
      end
      sts_pkg::ST_VEL: state_d = sts_pkg::ST_OUT;
      sts_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = sts_pkg::ST_IDLE;
          if (fin_q) begin
            pos_out_d = cfg.center_angle;
            vel_out_d = '0;
            clamped_d = 1'b0;
            done_d    = 1'b1;
          end else begin
            done_d    = 1'b0;
            // Lower limit is tested first
            if (pos_q < lower_s) begin
              pos_out_d = cfg.lower_limit;
              vel_out_d = '0;
              clamped_d = 1'b1;
            end else if (pos_q > upper_s) begin
              pos_out_d = cfg.upper_limit;
              vel_out_d = '0;
              clamped_d = 1'b1;
            end else begin
              pos_out_d = pos_q[15:0];
              vel_out_d = vel_sat;
              clamped_d = 1'b0;
            end
            phase_d = phase_q + cfg.phase_step;
            cnt_d   = cnt_q + 24'd1;
          end
        end
      end
      default: state_d = sts_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sts_pkg::ST_IDLE;
      cnt_q       <= 24'd0;
      phase_q     <= 32'd0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    amp_q     <= amp_d;
    pos_q     <= pos_d;
    pos_out_q <= pos_out_d;
    vel_out_q <= vel_out_d;
    clamped_q <= clamped_d;
    done_q    <= done_d;
  end

  // A finished result carries no motion
  a_done_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (vel_out_q == '0 && !clamped_q))
    else $error("done result with motion");

  // A clamped result has zero velocity
  a_clamp_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clamped_q) |-> (vel_out_q == '0))
    else $error("clamped result with nonzero velocity");

  // No new tick while one is being worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("tick taken while busy");

  // A result only appears from the output step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sts_pkg::ST_OUT))
    else $error("result loaded outside output step");

endmodule

[dv/sts_setpoint_check.sv]
// Setpoint checker: mirrors the registers, predicts each tick's setpoint and compares results.
`timescale 1ns / 1ps

module sts_setpoint_check #(
  parameter int QTB = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  sts_cfg_if   cfg_ch,
  sts_in_if    in_ch,
  sts_out_if   out_ch,
  output int   pending_o,
  output int   fail_count_o
);

  localparam int  TBL_LEN   = 1 << QTB;
  localparam real PI_VAL    = 3.14159265358979323846;

  // Register values after reset
  localparam sts_pkg::cfg_t RESET_SETTING = '{
    phase_step:       32'd3865471,
    omega_rate:       17'd23162,
    center_angle:     16'sd0,
    preset_amplitude: 15'd3277,
    lower_limit:      -16'sd25736,
    upper_limit:      16'sd25736,
    run_ticks:        24'd300000,
    phase_offset:     32'd0
  };

  typedef struct packed {
    logic signed [15:0] pos;
    logic signed [19:0] vel;
    logic               clamp;
    logic               done;
  } setpoint_t;

  int            sine_q [TBL_LEN];
  sts_pkg::cfg_t shadow;
  logic [23:0]   ticks_run;
  logic [31:0]   phase;
  logic          halted;
  setpoint_t     setpoint_q [$];
  int            outstanding;
  int            errors;

  // Quarter-wave sine table, rounded to Q15
  initial begin
    for (int i = 0; i < TBL_LEN; i++) begin
      sine_q[i] = $rtoi(32767.0 * $sin((2.0 * i + 1.0) * PI_VAL / (4.0 * TBL_LEN)) + 0.5);
    end
  end

  function automatic longint quarter_wave(input logic [1:0] quad, input logic [QTB-1:0] idx);
    longint v;
    v = quad[0] ? sine_q[TBL_LEN - 1 - int'(idx)] : sine_q[idx];
    return quad[1] ? -v : v;
  endfunction

  // One control tick: updates run state and returns the setpoint it yields
  function automatic setpoint_t next_setpoint(input logic rs, input logic sp);
    setpoint_t r;
    longint    ctr, lo, hi, du, dl, safe, amp, pre, om, sv, cv, p, v;
    logic [1:0] quad;
    logic [QTB-1:0] idx;
    ctr = $signed(shadow.center_angle);
    lo  = $signed(shadow.lower_limit);
    hi  = $signed(shadow.upper_limit);
    pre = shadow.preset_amplitude;
    om  = shadow.omega_rate;
    r.pos   = shadow.center_angle;
    r.vel   = '0;
    r.clamp = 1'b0;
    if (rs) begin
      ticks_run = '0;
      phase     = shadow.phase_offset;
      halted    = 1'b0;
    end
    if (sp) halted = 1'b1;
    if (ticks_run >= shadow.run_ticks) halted = 1'b1;
    if (!halted) begin
      du   = hi - ctr;
      dl   = ctr - lo;
      safe = ((du < dl ? du : dl) * 26214) >>> 15;
      amp  = (pre < safe) ? pre : safe;
      quad = phase[31:30];
      idx  = phase[29 -: QTB];
      sv   = quarter_wave(quad, idx);
      cv   = quarter_wave(quad + 2'd1, idx);
      p    = ctr + ((amp * sv) >>> 15);
      v    = (((amp * om) >>> 13) * cv) >>> 15;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      // lower limit is tested first, so inverted limits resolve the same way
      if (p < lo) begin
        p = lo;
        v = 0;
        r.clamp = 1'b1;
      end else if (p > hi) begin
        p = hi;
        v = 0;
        r.clamp = 1'b1;
      end
      r.pos     = p[15:0];
      r.vel     = v[19:0];
      phase     = phase + shadow.phase_step;
      ticks_run = ticks_run + 24'd1;
    end
    r.done = halted;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: setpoint %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Watch the three channels at each clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    setpoint_t want;
    if (!rst_ni) begin
      shadow      = RESET_SETTING;
      ticks_run   = '0;
      phase       = RESET_SETTING.phase_offset;
      halted      = 1'b0;
      setpoint_q.delete();
      outstanding = 0;
      errors      = 0;
    end else begin
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (sts_pkg::cfg_idx_e'(cfg_ch.index))
          sts_pkg::REG_PHASE_STEP:   shadow.phase_step       = cfg_ch.data;
          sts_pkg::REG_OMEGA_RATE:   shadow.omega_rate       = cfg_ch.data[16:0];
          sts_pkg::REG_CENTER_ANGLE: shadow.center_angle     = cfg_ch.data[15:0];
          sts_pkg::REG_PRESET_AMP:   shadow.preset_amplitude = cfg_ch.data[14:0];
          sts_pkg::REG_LOWER_LIMIT:  shadow.lower_limit      = cfg_ch.data[15:0];
          sts_pkg::REG_UPPER_LIMIT:  shadow.upper_limit      = cfg_ch.data[15:0];
          sts_pkg::REG_RUN_TICKS:    shadow.run_ticks        = cfg_ch.data[23:0];
          sts_pkg::REG_PHASE_OFFSET: shadow.phase_offset     = cfg_ch.data;
          default: ;
        endcase
      end
      // tick items
      if (in_ch.valid && in_ch.ready) begin
        setpoint_q.push_back(next_setpoint(in_ch.restart, in_ch.stop_request));
        outstanding++;
      end
      // setpoint items
      if (out_ch.valid && out_ch.ready) begin
        if (setpoint_q.size() == 0) begin
          report_mismatch("unexpected item, position", out_ch.position_cmd, 0);
        end else begin
          want = setpoint_q.pop_front();
          outstanding--;
          if (out_ch.position_cmd !== want.pos)
            report_mismatch("position", out_ch.position_cmd, want.pos);
          if (out_ch.velocity_cmd !== want.vel)
            report_mismatch("velocity", out_ch.velocity_cmd, want.vel);
          if (out_ch.clamped !== want.clamp)
            report_mismatch("clamped", out_ch.clamped, want.clamp);
          if (out_ch.done_res !== want.done)
            report_mismatch("done", out_ch.done_res, want.done);
        end
      end
    end
    pending_o    <= outstanding;
    fail_count_o <= errors;
  end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, tick and register stimulus, and the final verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;

  // Settings at the ends of the register ranges (preset amplitude at most 25736)
  localparam sts_pkg::cfg_t ALL_MAX = '{
    phase_step:       32'hFFFF_FFFF,
    omega_rate:       17'h1FFFF,
    center_angle:     16'sd32767,
    preset_amplitude: 15'd25736,
    lower_limit:      -16'sd32768,
    upper_limit:      16'sd32767,
    run_ticks:        24'hFF_FFFF,
    phase_offset:     32'hFFFF_FFFF
  };
  localparam sts_pkg::cfg_t ALL_MIN = '{
    phase_step:       32'd0,
    omega_rate:       17'd0,
    center_angle:     -16'sd32768,
    preset_amplitude: 15'd0,
    lower_limit:      -16'sd32768,
    upper_limit:      -16'sd32768,
    run_ticks:        24'd0,
    phase_offset:     32'd0
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  int   pending;
  int   fail_count;
  int   in_max_gap;
  int   out_max_stall;
  int   cycles;

  sts_cfg_if cfg_ch ();
  sts_in_if  in_ch ();
  sts_out_if out_ch ();

  sine_trajectory_setpoint dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sts_setpoint_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_ch       (cfg_ch),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Send one tick item; valid stays high after acceptance for back-to-back items
  task automatic put_tick(input logic rs, input logic sp);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.restart      <= rs;
    in_ch.stop_request <= sp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop sending and wait for every outstanding setpoint
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input sts_pkg::cfg_idx_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic write_all(input sts_pkg::cfg_t c);
    write_reg(sts_pkg::REG_PHASE_STEP, c.phase_step);
    write_reg(sts_pkg::REG_OMEGA_RATE, {15'd0, c.omega_rate});
    write_reg(sts_pkg::REG_CENTER_ANGLE, {{16{c.center_angle[15]}}, c.center_angle});
    write_reg(sts_pkg::REG_PRESET_AMP, {17'd0, c.preset_amplitude});
    write_reg(sts_pkg::REG_LOWER_LIMIT, {{16{c.lower_limit[15]}}, c.lower_limit});
    write_reg(sts_pkg::REG_UPPER_LIMIT, {{16{c.upper_limit[15]}}, c.upper_limit});
    write_reg(sts_pkg::REG_RUN_TICKS, {8'd0, c.run_ticks});
    write_reg(sts_pkg::REG_PHASE_OFFSET, c.phase_offset);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly sane limits around the center; sometimes anything, inverted or outside
  function automatic sts_pkg::cfg_t draw_setting();
    sts_pkg::cfg_t c;
    int   lo, hi, ctr;
    c.phase_step       = $urandom();
    c.omega_rate       = $urandom_range(0, 131071);
    c.preset_amplitude = $urandom_range(0, 25736);
    c.phase_offset     = $urandom();
    c.run_ticks        = ($urandom_range(0, 4) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 40));
    if ($urandom_range(0, 3) == 0) begin
      lo  = int'($urandom_range(0, 65535)) - 32768;
      hi  = int'($urandom_range(0, 65535)) - 32768;
      ctr = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      lo  = -int'($urandom_range(0, 32768));
      hi  = $urandom_range(0, 32767);
      ctr = lo + int'($urandom_range(0, hi - lo));
    end
    c.lower_limit  = lo[15:0];
    c.upper_limit  = hi[15:0];
    c.center_angle = ctr[15:0];
    return c;
  endfunction

  // Result-side back-pressure
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, out_max_stall);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Main sequence
  initial begin
    sts_pkg::cfg_t setting;
    logic rs, sp;
    cycles             = 0;
    in_max_gap         = 3;
    out_max_stall      = 3;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.restart      = 1'b0;
    in_ch.stop_request = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = sts_pkg::REG_PHASE_STEP;
    cfg_ch.data        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: moving, restart, stop, finished hold, restart with stop, resume
    put_tick(1'b0, 1'b0);
    put_tick(1'b0, 1'b0);
    put_tick(1'b1, 1'b0);
    put_tick(1'b0, 1'b1);
    put_tick(1'b0, 1'b0);
    put_tick(1'b1, 1'b1);
    put_tick(1'b1, 1'b0);
    wait_drained();

    // eighth-turn steps through all quadrants; run ends after ten ticks;
    // new offset only counts from the restart on
    write_all('{phase_step: 32'h2000_0000, omega_rate: 17'h1FFFF, center_angle: 16'sd0,
                preset_amplitude: 15'd25736, lower_limit: -16'sd32768,
                upper_limit: 16'sd32767, run_ticks: 24'd10, phase_offset: 32'hFFFF_FFFF});
    put_tick(1'b0, 1'b0);
    put_tick(1'b1, 1'b0);
    repeat (10) put_tick(1'b0, 1'b0);
    wait_drained();

    // inverted limits clamp every moving tick
    write_all('{phase_step: 32'h4000_0000, omega_rate: 17'd8192, center_angle: -16'sd32768,
                preset_amplitude: 15'd1000, lower_limit: 16'sd100,
                upper_limit: -16'sd100, run_ticks: 24'd1000, phase_offset: 32'h8000_0000});
    put_tick(1'b1, 1'b0);
    put_tick(1'b0, 1'b0);
    put_tick(1'b0, 1'b0);
    wait_drained();

    // zero run length finishes at once
    write_reg(sts_pkg::REG_RUN_TICKS, 32'd0);
    cfg_ch.valid <= 1'b0;
    put_tick(1'b1, 1'b0);
    put_tick(1'b0, 1'b0);
    wait_drained();

    // random phases, each with its own setting and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      setting       = (ph == 0) ? ALL_MAX : (ph == 1) ? ALL_MIN : draw_setting();
      in_max_gap    = (ph % 3 == 1) ? 0 : 7;
      out_max_stall = (ph % 4 == 2) ? 0 : 7;
      write_all(setting);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rs = (n == 0) || ($urandom_range(0, 9) == 0);
        sp = ($urandom_range(0, 24) == 0);
        put_tick(rs, sp);
        if (n == PHASE_ITEMS / 2 && ph % 2 == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
